FILE: sv/rpa_pkg.sv
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types and codes of the reference-counted page allocator: transfer
// payloads, action and status codes, register indexes and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rpa_pkg;

  localparam int ADDR_W  = 32;
  localparam int CNT_W   = 8;
  localparam int STS_W   = 3;
  localparam int ACT_W   = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [ACT_W-1:0] ACT_INIT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_INC   = 2'd3;

  localparam logic [STS_W-1:0] STS_OK       = 3'd0;
  localparam logic [STS_W-1:0] STS_OOM      = 3'd1;
  localparam logic [STS_W-1:0] STS_BADADDR  = 3'd2;
  localparam logic [STS_W-1:0] STS_CORRUPT  = 3'd3;
  localparam logic [STS_W-1:0] STS_OVERFLOW = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP  = 1'b1;

  localparam logic [ADDR_W-1:0] START_RESET = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] STOP_RESET  = 32'h8800_0000;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] page_address;
    logic [STS_W-1:0]  status;
    logic [CNT_W-1:0]  count_after;
  } out_item_t;

  typedef struct packed {
    logic             capture;
    logic             sweep_start;
    logic             sweep_step;
    logic             sweep_push;
    logic             idx_from_addr;
    logic             idx_from_stack;
    logic             decide;
    logic             set_res;
    logic [STS_W-1:0] res_status;
    logic             load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             depth_zero;
    logic             addr_ok;
    logic             sweep_last;
    logic             out_free;
  } dp_status_t;

endpackage

FILE: sv/rpa_ram.sv
// ----------------------------------------------------------------------------
// rpa_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module rpa_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 256,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/rpa_ctrl.sv
// ----------------------------------------------------------------------------
// rpa_ctrl
// Sequencer of the page allocator: runs the count clearing pass after reset,
// the init sweep and the read-modify-write steps of alloc, free and
// increment, and hands each result to the output register.
// ----------------------------------------------------------------------------
module rpa_ctrl import rpa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t stat_i,
  output ctl_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SWEEP,
    S_POP,
    S_CNT_RD,
    S_DECIDE,
    S_EMIT
  } state_e;

  state_e   state_q, state_d;
  logic     in_stall_q;
  ctl_cmd_t cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      S_CLEAR: begin
        cmd.sweep_step = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i && !in_stall_q) begin
          cmd.capture = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        case (stat_i.action)
          ACT_INIT: begin
            cmd.sweep_start = 1'b1;
            state_d         = S_SWEEP;
          end
          ACT_ALLOC: begin
            if (stat_i.depth_zero) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = STS_OOM;
              state_d        = S_EMIT;
            end else begin
              state_d = S_POP;
            end
          end
          default: begin
            if (stat_i.addr_ok) begin
              cmd.idx_from_addr = 1'b1;
              state_d           = S_CNT_RD;
            end else begin
              cmd.set_res    = 1'b1;
              cmd.res_status = STS_BADADDR;
              state_d        = S_EMIT;
            end
          end
        endcase
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        cmd.sweep_push = 1'b1;
        if (stat_i.sweep_last) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = STS_OK;
          state_d        = S_EMIT;
        end
      end
      S_POP: begin
        cmd.idx_from_stack = 1'b1;
        state_d            = S_CNT_RD;
      end
      S_CNT_RD: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd.load_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      in_stall_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_stall_q <= (state_d != S_IDLE);
    end
  end

  assign in_stall_o = in_stall_q;
  assign cmd_o      = cmd;

`ifndef SYNTHESIS
  a_stall_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_q == (state_q != S_IDLE))
    else $error("input stall out of step with state");

  a_capture_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> in_stall_q && state_q == S_CHECK)
    else $error("accepted transfer not followed by busy check");

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> stat_i.out_free)
    else $error("result loaded over a waiting result");
`endif

endmodule

FILE: sv/rpa_dpath.sv
// ----------------------------------------------------------------------------
// rpa_dpath
// Datapath of the page allocator: configuration registers, address check,
// free-page stack and reference-count memories, stack pointer, sweep
// counter, result register and output register.
// ----------------------------------------------------------------------------
module rpa_dpath import rpa_pkg::*; #(
  parameter int PAGE_COUNT = 32768,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  input  in_item_t             in_data_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output out_item_t            out_data_o,
  input  ctl_cmd_t             cmd_i,
  output dp_status_t           stat_o
);

  localparam int IW = $clog2(PAGE_COUNT);
  localparam int DW = $clog2(PAGE_COUNT + 1);
  localparam logic [32:0]   PAGE_SIZE = 33'd1 << PAGE_SHIFT;
  localparam logic [32:0]   PAGE_MASK = PAGE_SIZE - 33'd1;
  localparam logic [DW-1:0] DEPTH_MAX = DW'(PAGE_COUNT);
  localparam logic [IW-1:0] IDX_LAST  = IW'(PAGE_COUNT - 1);

  logic [ADDR_W-1:0] start_q, stop_q;
  in_item_t          in_q;
  logic [IW-1:0]     idx_q;
  logic [DW-1:0]     depth_q;
  logic [IW-1:0]     sweep_q;
  logic [32:0]       page_q;
  out_item_t         res_q;
  out_item_t         out_q;
  logic              out_valid_q;

  logic [32:0]      base;
  logic [32:0]      addr_ext;
  logic [32:0]      diff;
  logic [32:0]      pg_off;
  logic             addr_ok;
  logic [33:0]      page_end;
  logic             fit;

  logic             stk_we;
  logic [IW-1:0]    stk_waddr, stk_wdata, stk_raddr, stk_rdata;
  logic             cnt_we;
  logic [IW-1:0]    cnt_waddr;
  logic [CNT_W-1:0] cnt_wdata, cnt_rdata;

  logic             dec_pop, dec_push, dec_cnt_we;
  logic [CNT_W-1:0] dec_cnt;
  out_item_t        dec_res;
  logic [CNT_W-1:0] cnt_less;

  always_comb begin
    base     = ({1'b0, start_q} + PAGE_MASK) & ~PAGE_MASK;
    addr_ext = {1'b0, in_q.address};
    diff     = addr_ext - base;
    pg_off   = diff >> PAGE_SHIFT;
    addr_ok  = ((addr_ext & PAGE_MASK) == 33'd0) && (in_q.address >= start_q) &&
               (in_q.address < stop_q) && (addr_ext >= base) &&
               (pg_off < 33'(PAGE_COUNT));
    page_end = {1'b0, page_q} + {1'b0, PAGE_SIZE};
    fit      = page_end <= {2'b00, stop_q};
  end

  always_comb begin
    dec_pop    = 1'b0;
    dec_push   = 1'b0;
    dec_cnt_we = 1'b0;
    dec_cnt    = '0;
    dec_res    = '0;
    cnt_less   = (cnt_rdata == '0) ? '0 : cnt_rdata - CNT_W'(1);
    case (in_q.action)
      ACT_ALLOC: begin
        if (cnt_rdata != '0) begin
          dec_res.status      = STS_CORRUPT;
          dec_res.count_after = cnt_rdata;
        end else begin
          dec_pop              = 1'b1;
          dec_cnt_we           = 1'b1;
          dec_cnt              = CNT_W'(1);
          dec_res.count_after  = CNT_W'(1);
          dec_res.page_address = ADDR_W'(base + (33'(idx_q) << PAGE_SHIFT));
        end
      end
      ACT_FREE: begin
        dec_cnt_we          = 1'b1;
        dec_cnt             = cnt_less;
        dec_res.count_after = cnt_less;
        if (cnt_less == '0) begin
          if (depth_q < DEPTH_MAX) begin
            dec_push = 1'b1;
          end else begin
            dec_res.status = STS_OVERFLOW;
          end
        end
      end
      ACT_INC: begin
        if (cnt_rdata == CNT_MAX) begin
          dec_res.status      = STS_OVERFLOW;
          dec_res.count_after = CNT_MAX;
        end else begin
          dec_cnt_we          = 1'b1;
          dec_cnt             = cnt_rdata + CNT_W'(1);
          dec_res.count_after = cnt_rdata + CNT_W'(1);
        end
      end
      default: begin
        dec_res = '0;
      end
    endcase
  end

  always_comb begin
    stk_raddr = IW'(depth_q - DW'(1));
    if (cmd_i.sweep_step) begin
      stk_we    = cmd_i.sweep_push && fit;
      stk_waddr = sweep_q;
      stk_wdata = sweep_q;
      cnt_we    = 1'b1;
      cnt_waddr = sweep_q;
      cnt_wdata = '0;
    end else begin
      stk_we    = cmd_i.decide && dec_push;
      stk_waddr = IW'(depth_q);
      stk_wdata = idx_q;
      cnt_we    = cmd_i.decide && dec_cnt_we;
      cnt_waddr = idx_q;
      cnt_wdata = dec_cnt;
    end
  end

  rpa_ram #(.WIDTH(IW), .DEPTH(PAGE_COUNT)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  rpa_ram #(.WIDTH(CNT_W), .DEPTH(PAGE_COUNT)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (idx_q),
    .rdata_o (cnt_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= START_RESET;
      stop_q      <= STOP_RESET;
      depth_q     <= '0;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_START: start_q <= cfg_data_i;
          CFG_STOP:  stop_q  <= cfg_data_i;
          default:   start_q <= start_q;
        endcase
      end
      if (cmd_i.sweep_start) begin
        depth_q <= '0;
        sweep_q <= '0;
      end else if (cmd_i.sweep_step) begin
        sweep_q <= sweep_q + IW'(1);
        if (cmd_i.sweep_push && fit) begin
          depth_q <= DW'(sweep_q) + DW'(1);
        end
      end else if (cmd_i.decide && dec_pop) begin
        depth_q <= depth_q - DW'(1);
      end else if (cmd_i.decide && dec_push) begin
        depth_q <= depth_q + DW'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
    if (cmd_i.idx_from_addr) begin
      idx_q <= pg_off[IW-1:0];
    end else if (cmd_i.idx_from_stack) begin
      idx_q <= stk_rdata;
    end
    if (cmd_i.sweep_start) begin
      page_q <= base;
    end else if (cmd_i.sweep_step && fit) begin
      page_q <= page_q + PAGE_SIZE;
    end
    if (cmd_i.set_res) begin
      res_q <= '{page_address: '0, status: cmd_i.res_status, count_after: '0};
    end else if (cmd_i.decide) begin
      res_q <= dec_res;
    end
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign stat_o.action     = in_q.action;
  assign stat_o.depth_zero = (depth_q == '0);
  assign stat_o.addr_ok    = addr_ok;
  assign stat_o.sweep_last = (sweep_q == IDX_LAST);
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_MAX)
    else $error("free stack pointer past capacity");

  a_page_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.page_address != '0 |->
      out_q.status == STS_OK && (33'(out_q.page_address) & PAGE_MASK) == 33'd0)
    else $error("allocated page not aligned or not ok");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.status <= STS_OVERFLOW)
    else $error("status code out of range");
`endif

endmodule

FILE: sv/refcounted_page_allocator.sv
// ----------------------------------------------------------------------------
// refcounted_page_allocator
// Physical page allocator with a LIFO free-page stack and an 8-bit reference
// count per page.
// ----------------------------------------------------------------------------
// After reset the block clears every reference count, one page per cycle,
// and takes no input transfer until that pass is done; configuration writes
// are taken at any time. Each transfer yields exactly one result. The init
// sweep writes one count per cycle and one stack entry per page that fits.
// Alloc reads the stack and then the count memory, free and increment only
// the count memory, each read registered, before the read-modify-write ends;
// a rejected address or an empty stack goes straight to the result. A new
// transfer is taken once the result of the previous one sits in the output
// register.
module refcounted_page_allocator import rpa_pkg::*; #(
  parameter int PAGE_COUNT = 32768,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o
);

  ctl_cmd_t   cmd;
  dp_status_t stat;

  assign cfg_ready_o = 1'b1;

  rpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rpa_dpath #(
    .PAGE_COUNT (PAGE_COUNT),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the reference-counted page allocator. A driver
// offers queued actions with random gaps and a monitor takes results with
// random stalls. An in-bench model of the free-page stack and the per-page
// counts predicts each result, which is compared field by field. The run
// steps through several memory regions (full, tiny, empty, wrapped, random),
// covering double free, corrupt counts, stack overflow and count saturation.
// ----------------------------------------------------------------------------
module testbench;
  import rpa_pkg::*;

  localparam int PG_CNT   = 32768;
  localparam int PG_SHIFT = 12;
  localparam int PG_IDX_W = $clog2(PG_CNT);
  localparam logic [33:0] PG_SIZE = 34'd1 << PG_SHIFT;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_START;
  logic [ADDR_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_data = '0;
  logic                 out_valid_o;
  logic                 out_stall = 1'b0;
  out_item_t            out_data_o;

  // allocator model state
  logic [ADDR_W-1:0]   cfg_start = START_RESET;
  logic [ADDR_W-1:0]   cfg_stop = STOP_RESET;
  logic [PG_IDX_W-1:0] free_pages [PG_CNT];
  int unsigned         free_depth = 0;
  logic [CNT_W-1:0]    page_refs [PG_CNT];

  in_item_t          action_q[$];
  out_item_t         predicted_replies[$];
  logic [ADDR_W-1:0] handed_out[$];

  int  tx_gap = 0;
  int  rx_wait = 0;
  int  rx_long_tok = 0;
  int  rx_long_seen = 0;
  int  spare_inits = 3;
  int  fail_cnt = 0;
  bit  no_idle = 1'b0;

  refcounted_page_allocator #(
    .PAGE_COUNT(PG_CNT),
    .PAGE_SHIFT(PG_SHIFT)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  function automatic logic [33:0] region_base();
    return ({2'b00, cfg_start} + PG_SIZE - 34'd1) & ~(PG_SIZE - 34'd1);
  endfunction

  function automatic bit page_of(input logic [ADDR_W-1:0] addr,
                                 output logic [PG_IDX_W-1:0] idx);
    logic [33:0] off;
    idx = '0;
    if (addr[PG_SHIFT-1:0] != '0) return 1'b0;
    if (addr < cfg_start || addr >= cfg_stop) return 1'b0;
    if ({2'b00, addr} < region_base()) return 1'b0;
    off = ({2'b00, addr} - region_base()) >> PG_SHIFT;
    if (off >= PG_CNT) return 1'b0;
    idx = off[PG_IDX_W-1:0];
    return 1'b1;
  endfunction

  function automatic out_item_t allocator_step(input in_item_t it);
    out_item_t           r;
    logic [PG_IDX_W-1:0] idx;
    logic [33:0]         p;
    r = '0;
    r.status = STS_OK;
    case (it.action)
      ACT_INIT: begin
        foreach (page_refs[i]) page_refs[i] = '0;
        free_depth = 0;
        p = region_base();
        while (free_depth < PG_CNT && p + PG_SIZE <= {2'b00, cfg_stop}) begin
          free_pages[free_depth] = PG_IDX_W'(free_depth);
          free_depth++;
          p += PG_SIZE;
        end
      end
      ACT_ALLOC: begin
        if (free_depth == 0) begin
          r.status = STS_OOM;
        end else begin
          idx = free_pages[free_depth-1];
          if (page_refs[idx] != '0) begin
            r.status = STS_CORRUPT;
            r.count_after = page_refs[idx];
          end else begin
            free_depth--;
            page_refs[idx] = 8'd1;
            r.count_after = 8'd1;
            r.page_address = ADDR_W'(region_base() + (34'(idx) << PG_SHIFT));
            handed_out.push_back(r.page_address);
            if (handed_out.size() > 48) void'(handed_out.pop_front());
          end
        end
      end
      ACT_FREE: begin
        if (!page_of(it.address, idx)) begin
          r.status = STS_BADADDR;
        end else begin
          if (page_refs[idx] != '0) page_refs[idx]--;
          if (page_refs[idx] == '0) begin
            if (free_depth >= PG_CNT) begin
              r.status = STS_OVERFLOW;
            end else begin
              free_pages[free_depth] = idx;
              free_depth++;
            end
          end
          r.count_after = page_refs[idx];
        end
      end
      default: begin
        if (!page_of(it.address, idx)) begin
          r.status = STS_BADADDR;
        end else begin
          if (page_refs[idx] == CNT_MAX) r.status = STS_OVERFLOW;
          else page_refs[idx]++;
          r.count_after = page_refs[idx];
        end
      end
    endcase
    return r;
  endfunction

  function automatic int draw_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ADDR_W-1:0] some_page();
    logic [33:0] b;
    logic [33:0] n;
    b = region_base();
    n = ({2'b00, cfg_stop} > b) ? (({2'b00, cfg_stop} - b) >> PG_SHIFT) : 34'd0;
    if (n > PG_CNT) n = PG_CNT;
    if (n == 0) return $urandom() & ~32'hFFF;
    return ADDR_W'(b + (34'($urandom_range(0, int'(n[16:0]) - 1)) << PG_SHIFT));
  endfunction

  function automatic logic [ADDR_W-1:0] stray_addr();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return some_page() | ADDR_W'($urandom_range(1, 4095));
      2: return cfg_stop;
      3: return (cfg_start & ~32'hFFF) - 32'h1000;
      default: return some_page() + ADDR_W'(PG_CNT << PG_SHIFT);
    endcase
  endfunction

  task automatic send(input logic [ACT_W-1:0] act, input logic [ADDR_W-1:0] addr);
    while (action_q.size() >= 4) @(negedge clk_i);
    action_q.push_back(in_item_t'{action: act, address: addr});
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (action_q.size() != 0 || in_valid || predicted_replies.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == CFG_START) cfg_start = val;
    else cfg_stop = val;
  endtask

  task automatic set_region(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
    settle();
    no_idle = ($urandom_range(0, 3) == 0);
    write_reg(CFG_START, lo);
    write_reg(CFG_STOP, hi);
    @(negedge clk_i);
    send(ACT_INIT, $urandom());
  endtask

  task automatic run_random(input int n);
    int r;
    int k;
    logic [ADDR_W-1:0] a;
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      if (r < 38) begin
        send(ACT_ALLOC, $urandom());
      end else if (r < 88) begin
        k = -1;
        if ($urandom_range(0, 9) < 7 && handed_out.size() != 0) begin
          k = $urandom_range(0, handed_out.size() - 1);
          a = handed_out[k];
        end else if ($urandom_range(0, 4) != 0) begin
          a = some_page();
        end else begin
          a = stray_addr();
        end
        if (r < 68) begin
          if (k >= 0 && $urandom_range(0, 1) == 1) handed_out.delete(k);
          send(ACT_FREE, a);
        end else begin
          send(ACT_INC, a);
        end
      end else if (r < 98) begin
        send(ACT_W'($urandom_range(1, 3)), stray_addr());
      end else if (spare_inits != 0) begin
        spare_inits--;
        send(ACT_INIT, $urandom());
      end else begin
        send(ACT_ALLOC, '0);
      end
    end
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #30_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
      tx_gap <= 0;
    end else begin
      if (in_valid && !in_stall_o) predicted_replies.push_back(allocator_step(in_data));
      if (!in_valid || !in_stall_o) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (action_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= action_q.pop_front();
          tx_gap <= draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    int g;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      rx_wait <= 0;
      rx_long_seen <= 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (predicted_replies.size() == 0) begin
          $error("result with no pending action: %p", out_data_o);
          fail_cnt++;
        end else begin
          want = predicted_replies.pop_front();
          if (out_data_o.page_address !== want.page_address) begin
            $error("page_address: expected %h, got %h", want.page_address,
                   out_data_o.page_address);
            fail_cnt++;
          end
          if (out_data_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data_o.status);
            fail_cnt++;
          end
          if (out_data_o.count_after !== want.count_after) begin
            $error("count_after: expected %0d, got %0d", want.count_after,
                   out_data_o.count_after);
            fail_cnt++;
          end
        end
      end
      if (rx_long_seen != rx_long_tok) begin
        rx_long_seen <= rx_long_tok;
        rx_wait <= 400;
        out_stall <= 1'b1;
      end else if (rx_wait != 0) begin
        rx_wait <= rx_wait - 1;
        out_stall <= 1'b1;
      end else begin
        g = draw_gap();
        out_stall <= (g != 0);
        rx_wait <= (g > 1) ? g - 1 : 0;
      end
    end
  end

  initial begin
    logic [ADDR_W-1:0] lo;
    foreach (page_refs[i]) page_refs[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send(ACT_ALLOC, '0);
    send(ACT_FREE, START_RESET);
    send(ACT_INC, START_RESET);
    send(ACT_ALLOC, '1);
    send(ACT_INIT, 32'hFFFF_FFFF);
    send(ACT_FREE, START_RESET);
    send(ACT_ALLOC, '0);
    send(ACT_ALLOC, '0);
    send(ACT_FREE, 32'h87FF_F000);
    send(ACT_FREE, 32'h87FF_F000);
    send(ACT_ALLOC, '0);
    send(ACT_ALLOC, '0);
    send(ACT_INC, 32'h87FF_E000);
    send(ACT_FREE, 32'h87FF_E000);
    send(ACT_FREE, 32'h87FF_E001);
    send(ACT_INC, 32'h7FFF_F000);
    send(ACT_FREE, STOP_RESET);
    send(ACT_INC, 32'hFFFF_FFFF);
    send(ACT_FREE, 32'h0000_0000);
    send(ACT_INC, 32'h87FF_F000);

    set_region(32'h0000_0000, 32'hFFFF_FFFF);
    run_random(10);
    rx_long_tok++;
    run_random(60);

    set_region(32'h0010_0801, 32'h0010_5000);
    run_random(90);

    // move the base under a filled stack
    settle();
    write_reg(CFG_START, 32'h0010_2000);
    @(negedge clk_i);
    run_random(40);

    set_region(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(ACT_ALLOC, '0);
    send(ACT_FREE, 32'hFFFF_F000);
    send(ACT_INC, 32'hFFFF_F000);
    run_random(10);

    set_region(32'h0000_0000, 32'h0000_0000);
    send(ACT_FREE, 32'h0000_0000);
    run_random(10);

    set_region(32'h4000_0000, 32'h4001_0000);
    send(ACT_ALLOC, '0);
    repeat (256) send(ACT_INC, 32'h4000_F000);
    repeat (3) send(ACT_FREE, 32'h4000_F000);
    run_random(20);

    repeat (3) begin
      lo = $urandom();
      set_region(lo, lo + ADDR_W'($urandom_range(1, 64) * 4096) +
                 ADDR_W'($urandom_range(0, 4095)));
      run_random(60);
    end

    set_region(START_RESET, STOP_RESET);
    run_random(70);

    settle();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && predicted_replies.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
